// ===== hdl/imu_frame_deframer_macros.svh =====
// ---------------------------------------------------------------------------
// IMU frame deframer assertion macros
// Shared concurrent assertion forms; clocked on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef IMU_FRAME_DEFRAMER_MACROS_SVH
`define IMU_FRAME_DEFRAMER_MACROS_SVH

// Check that a condition holds at every clock edge outside reset
`define IFD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define IFD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define IFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ifd_pkg.sv =====
// ---------------------------------------------------------------------------
// IMU frame deframer package
// Frame constants, register indexes and the frame record type.
// ---------------------------------------------------------------------------
`default_nettype none

package ifd_pkg;

   // Frame layout
   localparam logic [7:0] HDR_BYTE   = 8'h55;
   localparam logic [7:0] TAG_ACCEL  = 8'h51;
   localparam logic [7:0] TAG_GYRO   = 8'h52;
   localparam logic [3:0] CNT_IDLE   = 4'd0;
   localparam logic [3:0] CNT_TAG    = 4'd1;
   localparam logic [3:0] CNT_AXIS   = 4'd2;   // first axis byte position
   localparam logic [3:0] FRAME_LAST = 4'd10;  // position of the check byte
   localparam int         AXIS_BYTES = 6;

   // Field widths
   localparam int RAW_W   = 16;
   localparam int ACCEL_W = 8;
   localparam int GYRO_W  = 12;
   localparam int AXIS_W  = 28;
   localparam int PROD_W  = RAW_W + GYRO_W + 1;

   // Result kinds
   localparam logic KIND_ACCEL = 1'b0;
   localparam logic KIND_GYRO  = 1'b1;

   // Configuration register indexes
   localparam int          CSR_IDX_W       = 1;
   localparam int          CSR_DATA_W      = GYRO_W;
   localparam logic [0:0]  CSR_ACCEL_RANGE = 1'b0;
   localparam logic [0:0]  CSR_GYRO_RANGE  = 1'b1;

   // One checked frame on its way to the scaler
   typedef struct packed {
      logic                    kind;
      logic signed [RAW_W-1:0] axis_x;
      logic signed [RAW_W-1:0] axis_y;
      logic signed [RAW_W-1:0] axis_z;
   } frame_type;

endpackage

`default_nettype wire

// ===== hdl/ifd_framer.sv =====
// ---------------------------------------------------------------------------
// IMU frame deframer: byte framer
// Hunts for the header, collects the frame, checks the sum and the tag and
// registers one frame record per good frame.
// ---------------------------------------------------------------------------
`default_nettype none

module ifd_framer (
   input  wire                clock,
   input  wire                reset,
   input  wire                byte_valid,
   output logic               byte_ready,
   input  wire  [7:0]         byte_data,
   input  wire                frame_pop,
   output logic               frame_valid,
   output ifd_pkg::frame_type frame
);

   logic [3:0]         count_ff, count_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         tag_ff;
   logic [7:0]         axis_bytes_ff [ifd_pkg::AXIS_BYTES];
   logic               frame_valid_ff, frame_valid_in;
   ifd_pkg::frame_type frame_ff, frame_in;
   logic               accept;
   logic               at_check;
   logic               good_frame;

   // Hold off the check byte only while the frame register is still full
   assign at_check   = (count_ff == ifd_pkg::FRAME_LAST);
   assign byte_ready = !at_check || !frame_valid_ff;
   assign accept     = byte_valid && byte_ready;

   // Sum must match and the tag must be a known sensor
   assign good_frame = (sum_ff == byte_data) &&
                       ((tag_ff == ifd_pkg::TAG_ACCEL) || (tag_ff == ifd_pkg::TAG_GYRO));

   // Advance the frame position and the running sum
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (accept) begin
         priority if (count_ff == ifd_pkg::CNT_IDLE) begin
            if (byte_data == ifd_pkg::HDR_BYTE) begin
               count_in = ifd_pkg::CNT_TAG;
               sum_in   = byte_data;
            end
         end else if (at_check) begin
            count_in = ifd_pkg::CNT_IDLE;
            sum_in   = 8'd0;
         end else begin
            count_in = count_ff + 4'd1;
            sum_in   = sum_ff + byte_data;
         end
      end
   end

   // Build the frame record from the stored bytes
   always_comb begin
      frame_in.kind   = (tag_ff == ifd_pkg::TAG_GYRO) ? ifd_pkg::KIND_GYRO
                                                      : ifd_pkg::KIND_ACCEL;
      frame_in.axis_x = {axis_bytes_ff[1], axis_bytes_ff[0]};
      frame_in.axis_y = {axis_bytes_ff[3], axis_bytes_ff[2]};
      frame_in.axis_z = {axis_bytes_ff[5], axis_bytes_ff[4]};
   end

   // Load the frame register on a good frame, drop it when the scaler takes it
   always_comb begin
      frame_valid_in = frame_valid_ff;
      if (frame_pop) begin
         frame_valid_in = 1'b0;
      end
      if (accept && at_check && good_frame) begin
         frame_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= ifd_pkg::CNT_IDLE;
         sum_ff         <= 8'd0;
         frame_valid_ff <= 1'b0;
      end else begin
         count_ff       <= count_in;
         sum_ff         <= sum_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   // Capture tag and axis bytes at their frame positions
   always_ff @(posedge clock) begin
      if (accept && (count_ff == ifd_pkg::CNT_TAG)) begin
         tag_ff <= byte_data;
      end
      for (int i = 0; i < ifd_pkg::AXIS_BYTES; i++) begin
         if (accept && (count_ff == (ifd_pkg::CNT_AXIS + 4'(i)))) begin
            axis_bytes_ff[i] <= byte_data;
         end
      end
      if (accept && at_check) begin
         frame_ff <= frame_in;
      end
   end

   assign frame_valid = frame_valid_ff;
   assign frame       = frame_ff;

endmodule

`default_nettype wire

// ===== hdl/ifd_scaler.sv =====
// ---------------------------------------------------------------------------
// IMU frame deframer: axis scaler
// Multiplies the three raw axes by the selected range and holds the result
// in the output register until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module ifd_scaler (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  frame_valid,
   input  ifd_pkg::frame_type                   frame,
   output logic                                 frame_pop,
   input  wire  [ifd_pkg::ACCEL_W-1:0]          accel_range,
   input  wire  [ifd_pkg::GYRO_W-1:0]           gyro_range,
   output logic                                 out_valid,
   input  wire                                  out_ready,
   output logic                                 out_kind,
   output logic [3*ifd_pkg::AXIS_W-1:0]         out_axes
);

   logic signed [ifd_pkg::GYRO_W:0]    range_s;
   logic signed [ifd_pkg::PROD_W-1:0]  prod_x, prod_y, prod_z;
   logic                               out_valid_ff, out_valid_in;
   logic                               kind_ff;
   logic [3*ifd_pkg::AXIS_W-1:0]       axes_ff, axes_in;
   logic                               load;

   // Output register takes a new result when empty or being drained
   assign load      = !out_valid_ff || out_ready;
   assign frame_pop = load && frame_valid;

   // Select the range for the frame kind, kept non-negative
   assign range_s = (frame.kind == ifd_pkg::KIND_GYRO)
                    ? $signed({1'b0, gyro_range})
                    : $signed({1'b0, (ifd_pkg::GYRO_W)'(accel_range)});

   assign prod_x = frame.axis_x * range_s;
   assign prod_y = frame.axis_y * range_s;
   assign prod_z = frame.axis_z * range_s;

   assign axes_in = {prod_z[ifd_pkg::AXIS_W-1:0],
                     prod_y[ifd_pkg::AXIS_W-1:0],
                     prod_x[ifd_pkg::AXIS_W-1:0]};

   assign out_valid_in = load ? frame_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the payload while stalled
   always_ff @(posedge clock) begin
      if (frame_pop) begin
         kind_ff <= frame.kind;
         axes_ff <= axes_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_kind  = kind_ff;
   assign out_axes  = axes_ff;

endmodule

`default_nettype wire

// ===== hdl/imu_frame_deframer.sv =====
// Path: a result passes the frame register and then the output register after its
//   check byte is accepted, when the result side is not stalled.
// Throughput: one received byte per cycle; the check byte waits only while the
//   frame register still holds an earlier frame that the output stage has not taken.
// Reset: synchronous, active high; clears frame position, sum, valids and sets
//   the range registers to 16 and 2000.
// ---------------------------------------------------------------------------
// IMU frame deframer
// Finds 11-byte sensor frames in a byte request stream, checks them and
// returns the kind and the three range-scaled axes of each good frame.
// ---------------------------------------------------------------------------
`default_nettype none

module imu_frame_deframer (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [7:0]                         req_tdata,   // [7:0] rx_byte
   // result channel
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [87:0]                        rsp_tdata,   // axis_x, axis_y, axis_z, zero pad
   output logic                               rsp_tuser,   // [0] kind
   // configuration port
   input  wire                                csr_wr_en,
   input  wire  [ifd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [ifd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [ifd_pkg::ACCEL_W-1:0]   accel_range_ff;
   logic [ifd_pkg::GYRO_W-1:0]    gyro_range_ff;
   logic                          frame_valid;
   logic                          frame_pop;
   ifd_pkg::frame_type            frame;
   logic [3*ifd_pkg::AXIS_W-1:0]  axes;

   // Range registers
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_range_ff <= 8'd16;
         gyro_range_ff  <= 12'd2000;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ifd_pkg::CSR_ACCEL_RANGE: accel_range_ff <= csr_wdata[ifd_pkg::ACCEL_W-1:0];
            ifd_pkg::CSR_GYRO_RANGE:  gyro_range_ff  <= csr_wdata;
         endcase
      end
   end

   ifd_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_tvalid),
      .byte_ready  (req_tready),
      .byte_data   (req_tdata),
      .frame_pop   (frame_pop),
      .frame_valid (frame_valid),
      .frame       (frame)
   );

   ifd_scaler u_scaler (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame       (frame),
      .frame_pop   (frame_pop),
      .accel_range (accel_range_ff),
      .gyro_range  (gyro_range_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_kind    (rsp_tuser),
      .out_axes    (axes)
   );

   // Pack axes from the lowest bit up, pad to whole bytes
   assign rsp_tdata = {4'd0, axes};

endmodule

`default_nettype wire

// ===== hdl/ifd_checker.sv =====
// ---------------------------------------------------------------------------
// IMU frame deframer port checker
// Watches the top-level ports for result timing and handshake slips.
// ---------------------------------------------------------------------------
`default_nettype none

`include "imu_frame_deframer_macros.svh"

module ifd_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [87:0] rsp_tdata,
   input wire        rsp_tuser
);

   logic        req_take;
   logic        rsp_stall;
   logic [88:0] rsp_word;

   assign req_take  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tuser, rsp_tdata};

   // A stalled result stays put
   `IFD_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word), "stalled result changed")

   // A fresh result follows an accepted request
   `IFD_ASSERT_IMPLY(a_rsp_cause, $rose(rsp_tvalid), $past(req_take, 2), "result without a request")

   // Pad bits of a result are zero
   `IFD_ASSERT_IMPLY(a_rsp_pad, rsp_tvalid, rsp_tdata[87:84] == 4'd0, "result pad bits set")

   // A valid result carries a known kind
   `IFD_ASSERT_ALWAYS(a_rsp_known, !rsp_tvalid || !$isunknown(rsp_tuser), "result kind unknown")

endmodule

bind imu_frame_deframer ifd_checker u_ifd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
